@@ src/rlq_pkg.sv @@
// Package for the run-length queue: state encoding, transaction kind and status codes.
// No dependencies; imported by the top level.
package rlq_pkg;

   localparam int RUN_W  = 24;
   localparam int TAKE_W = 32;
   localparam int SUM_W  = 56;
   localparam int STAT_W = 2;

   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_TAKE = 1'b1;

   localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_UNDERFLOW = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TAKE_READ,
      ST_TAKE_MULT,
      ST_TAKE_ACC,
      ST_DONE
   } state_type;

endpackage

@@ src/rlq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used by the top level to hold the stored runs.
module rlq_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/run_length_queue_take_sum_top.sv @@
// Sequencing: an accepted push goes to ST_DONE, which registers its result; a take goes
// through ST_TAKE_READ, ST_TAKE_MULT and ST_TAKE_ACC per stored run touched (read, multiply,
// accumulate through one shared 32x24 multiplier and one RAM port), then to ST_DONE.
// One transaction is in work at a time; a held result stalls input.
// Reset (synchronous): clears head, tail, occupancy, sequencer and output valid; the run
// storage is not cleared and needs no clearing pass. Depends on rlq_pkg and rlq_ram.
module run_length_queue_take_sum_top
   import rlq_pkg::*;
#(
   parameter int DEPTH = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_kind,
   input  logic [RUN_W-1:0]  req_run_count,
   input  logic [RUN_W-1:0]  req_run_value,
   input  logic [TAKE_W-1:0] req_take_count,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [SUM_W-1:0]  rsp_sum,
   output logic [STAT_W-1:0] rsp_status
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int OCC_W = $clog2(DEPTH + 1);
   localparam int ENT_W = 2 * RUN_W;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [IDX_W-1:0]  tail_ff, tail_in;
   logic [OCC_W-1:0]  occ_ff, occ_in;
   logic [TAKE_W-1:0] want_ff, want_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [SUM_W-1:0]  prod_ff, prod_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]  rsp_sum_ff, rsp_sum_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;

   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   logic [ENT_W-1:0]  ram_wr_data;
   logic              ram_rd_en;
   logic [ENT_W-1:0]  ram_rd_data;

   logic              accept;
   logic              full;
   logic [RUN_W-1:0]  have;
   logic [RUN_W-1:0]  value;
   logic              partial;
   logic [TAKE_W-1:0] mul_a;

   rlq_ram #(
      .WIDTH(ENT_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(head_ff),
      .rd_data(ram_rd_data)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign full       = (occ_ff == OCC_W'(DEPTH));
   assign have       = ram_rd_data[ENT_W-1:RUN_W];
   assign value      = ram_rd_data[RUN_W-1:0];
   assign partial    = ({{(TAKE_W-RUN_W){1'b0}}, have} > want_ff);
   assign mul_a      = partial ? want_ff : {{(TAKE_W-RUN_W){1'b0}}, have};
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sum    = rsp_sum_ff;
   assign rsp_status = rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      want_ff       <= want_in;
      sum_ff        <= sum_in;
      prod_ff       <= prod_in;
      status_ff     <= status_in;
      rsp_sum_ff    <= rsp_sum_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      occ_in        = occ_ff;
      want_in       = want_ff;
      sum_in        = sum_ff;
      prod_in       = prod_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_sum_in    = rsp_sum_ff;
      rsp_status_in = rsp_status_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = tail_ff;
      ram_wr_data   = {req_run_count, req_run_value};
      ram_rd_en     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sum_in    = '0;
               want_in   = req_take_count;
               status_in = STATUS_OK;
               if (req_kind == KIND_PUSH) begin
                  state_in = ST_DONE;
                  if (full) begin
                     status_in = STATUS_FULL;
                  end else if (req_run_count != '0) begin
                     ram_wr_en = 1'b1;
                     tail_in   = (tail_ff == IDX_W'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
                     occ_in    = occ_ff + 1'b1;
                  end
               end else begin
                  state_in = ST_TAKE_READ;
               end
            end
         end
         ST_TAKE_READ: begin
            if (want_ff == '0 || occ_ff == '0) begin
               status_in = (want_ff != '0) ? STATUS_UNDERFLOW : STATUS_OK;
               state_in  = ST_DONE;
            end else begin
               ram_rd_en = 1'b1;
               state_in  = ST_TAKE_MULT;
            end
         end
         ST_TAKE_MULT: begin
            prod_in = {{(SUM_W-TAKE_W){1'b0}}, mul_a} * {{(SUM_W-RUN_W){1'b0}}, value};
            if (partial) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = head_ff;
               ram_wr_data = {have - want_ff[RUN_W-1:0], value};
               want_in     = '0;
            end else begin
               head_in = (head_ff == IDX_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
               occ_in  = occ_ff - 1'b1;
               want_in = want_ff - {{(TAKE_W-RUN_W){1'b0}}, have};
            end
            state_in = ST_TAKE_ACC;
         end
         ST_TAKE_ACC: begin
            sum_in   = sum_ff + prod_ff;
            state_in = ST_TAKE_READ;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_sum_in    = sum_ff;
               rsp_status_in = status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) occ_ff <= OCC_W'(DEPTH))
      else $error("occupancy above depth");

   assert property (@(posedge clock) disable iff (reset)
      (occ_ff == '0) |-> (head_ff == tail_ff))
      else $error("empty ring with head and tail apart");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TAKE_MULT) |-> (have != '0))
      else $error("stored run with zero count");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && status_ff == STATUS_UNDERFLOW) |-> (occ_ff == '0))
      else $error("underflow with runs left");

   assert property (@(posedge clock) disable iff (reset)
      (accept && req_kind == KIND_PUSH) |=> (state_ff == ST_DONE && sum_ff == '0))
      else $error("push did not go straight to result");
`endif

endmodule

@@ sim/run_length_queue_take_sum_top_tb.sv @@
// Testbench for run_length_queue_take_sum_top: push/take transactions with random flow control.
// A scoreboard class predicts each sum and status from its own copy of the run ring.
// Depends on rlq_pkg and the run_length_queue_take_sum_top RTL.
`timescale 1ns / 1ps

module run_length_queue_take_sum_top_tb
   import rlq_pkg::*;
();

   localparam int RING_DEPTH     = 256;
   localparam int RANDOM_ITEMS   = 1130;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int HOLDOFF_AT     = 1500;
   localparam int SETTLE_CYCLES  = 20;
   localparam int REPORT_LIMIT   = 10;

   class rlq_sum_checker;
      logic [RUN_W-1:0]  counts [RING_DEPTH];
      logic [RUN_W-1:0]  values [RING_DEPTH];
      int unsigned       head;
      int unsigned       tail;
      int unsigned       occupancy;
      logic [SUM_W-1:0]  expected_sums [$];
      logic [STAT_W-1:0] expected_status [$];
      int                mismatches;

      function new();
         head       = 0;
         tail       = 0;
         occupancy  = 0;
         mismatches = 0;
      endfunction

      function int pending();
         return expected_sums.size();
      endfunction

      function logic [TAKE_W-1:0] units_stored();
         logic [63:0] total;
         int unsigned slot;
         total = '0;
         slot  = head;
         for (int unsigned n = 0; n < occupancy; n++) begin
            total += counts[slot];
            slot   = (slot + 1) % RING_DEPTH;
         end
         return total[TAKE_W-1:0];
      endfunction

      function logic [TAKE_W-1:0] head_run_units();
         return (occupancy == 0) ? '0 : TAKE_W'(counts[head]);
      endfunction

      function void apply_transaction(input logic kind, input logic [RUN_W-1:0] run_count,
                                      input logic [RUN_W-1:0] run_value,
                                      input logic [TAKE_W-1:0] take_count);
         logic [63:0]       want;
         logic [63:0]       have;
         logic [63:0]       acc;
         logic [STAT_W-1:0] status;
         want   = 64'(take_count);
         acc    = '0;
         status = STATUS_OK;
         if (kind == KIND_PUSH) begin
            if (occupancy >= RING_DEPTH) begin
               status = STATUS_FULL;
            end else if (run_count != 0) begin
               counts[tail] = run_count;
               values[tail] = run_value;
               tail         = (tail + 1) % RING_DEPTH;
               occupancy++;
            end
         end else begin
            while (want != 0 && occupancy != 0) begin
               have = 64'(counts[head]);
               if (have > want) begin
                  acc         += want * 64'(values[head]);
                  counts[head] = RUN_W'(have - want);
                  want         = '0;
               end else begin
                  acc  += have * 64'(values[head]);
                  want -= have;
                  head  = (head + 1) % RING_DEPTH;
                  occupancy--;
               end
            end
            if (want != 0) status = STATUS_UNDERFLOW;
         end
         expected_sums.push_back(acc[SUM_W-1:0]);
         expected_status.push_back(status);
      endfunction

      function void report(input string text);
         mismatches++;
         if (mismatches <= REPORT_LIMIT) $display("%s", text);
      endfunction

      function void check_result(input logic [SUM_W-1:0] sum, input logic [STAT_W-1:0] status);
         logic [SUM_W-1:0]  exp_sum;
         logic [STAT_W-1:0] exp_status;
         if (expected_sums.size() == 0) begin
            report($sformatf("unexpected result: sum %0h status %0d", sum, status));
            return;
         end
         exp_sum    = expected_sums.pop_front();
         exp_status = expected_status.pop_front();
         if (sum !== exp_sum)
            report($sformatf("sum mismatch: expected %0h actual %0h", exp_sum, sum));
         if (status !== exp_status)
            report($sformatf("status mismatch: expected %0d actual %0d", exp_status, status));
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic              req_kind;
   logic [RUN_W-1:0]  req_run_count;
   logic [RUN_W-1:0]  req_run_value;
   logic [TAKE_W-1:0] req_take_count;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [SUM_W-1:0]  rsp_sum;
   logic [STAT_W-1:0] rsp_status;

   rlq_sum_checker sum_checker;
   int             items_sent;
   int             burst_left;
   int             idle_cycles;

   run_length_queue_take_sum_top #(.DEPTH(RING_DEPTH)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_run_count  (req_run_count),
      .req_run_value  (req_run_value),
      .req_take_count (req_take_count),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sum        (rsp_sum),
      .rsp_status     (rsp_status)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sum_checker.check_result(rsp_sum, rsp_status);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_transaction(input logic kind, input logic [RUN_W-1:0] run_count,
                                   input logic [RUN_W-1:0] run_value,
                                   input logic [TAKE_W-1:0] take_count);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap        = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_run_count  <= run_count;
      req_run_value  <= run_value;
      req_take_count <= take_count;
      do @(posedge clock); while (!(req_valid && req_ready));
      sum_checker.apply_transaction(kind, run_count, run_value, take_count);
      items_sent++;
   endtask

   task automatic push_run(input logic [RUN_W-1:0] run_count, input logic [RUN_W-1:0] run_value);
      send_transaction(KIND_PUSH, run_count, run_value, TAKE_W'($urandom()));
   endtask

   task automatic take_units(input logic [TAKE_W-1:0] take_count);
      send_transaction(KIND_TAKE, RUN_W'($urandom()), RUN_W'($urandom()), take_count);
   endtask

   function automatic logic [RUN_W-1:0] pick_run_count();
      case ($urandom_range(0, 19))
         0:       return '0;
         1:       return '1;
         2, 3:    return RUN_W'($urandom());
         default: return RUN_W'($urandom_range(1, 12));
      endcase
   endfunction

   function automatic logic [RUN_W-1:0] pick_run_value();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return RUN_W'($urandom());
      endcase
   endfunction

   function automatic logic [TAKE_W-1:0] pick_take_count();
      logic [TAKE_W-1:0] total;
      logic [TAKE_W-1:0] first;
      total = sum_checker.units_stored();
      first = sum_checker.head_run_units();
      case ($urandom_range(0, 11))
         0:       return '0;
         1:       return first;
         2:       return first + 1;
         3:       return (first > 1) ? first - 1 : first;
         4:       return total;
         5:       return total + 1;
         6:       return TAKE_W'($urandom());
         7:       return TAKE_W'($urandom_range(1, 1000));
         default: return TAKE_W'($urandom_range(1, 40));
      endcase
   endfunction

   task automatic run_directed();
      take_units('0);
      take_units(32'd1);
      take_units('1);
      push_run('0, 24'd5);
      push_run('1, '1);
      push_run(24'd1, '0);
      push_run(24'd3, 24'd7);
      take_units('0);
      take_units(32'd1);
      take_units(32'h00FF_FFFE);
      take_units(32'd2);
      take_units(32'd3);
      push_run(24'd5, 24'd9);
      push_run(24'd4, 24'd2);
      take_units(32'd9);
      push_run(24'd10, 24'd1);
      take_units('1);
      push_run('1, 24'h123456);
      take_units(32'h8000_0000);
      push_run(24'h800000, 24'h800000);
      take_units(32'h00FF_FFFF);
   endtask

   task automatic run_random_traffic(input int target);
      int  pick;
      bit  first_phase;
      first_phase = 1'b1;
      while (items_sent < target) begin
         pick = first_phase ? 0 : $urandom_range(0, 7);
         first_phase = 1'b0;
         if (pick == 0) begin
            while (sum_checker.occupancy < RING_DEPTH && items_sent < target)
               push_run(pick_run_count(), pick_run_value());
            repeat ($urandom_range(1, 4)) push_run(pick_run_count(), pick_run_value());
         end else if (pick <= 2) begin
            repeat ($urandom_range(3, 12)) begin
               if (items_sent < target) take_units(pick_take_count());
            end
         end else if (pick <= 5) begin
            repeat ($urandom_range(20, 80)) begin
               if (items_sent >= target) break;
               if ($urandom_range(0, 1) == 0) push_run(pick_run_count(), pick_run_value());
               else take_units(pick_take_count());
            end
         end else begin
            repeat ($urandom_range(20, 80)) begin
               if (items_sent >= target) break;
               if ($urandom_range(0, 4) != 0) push_run(pick_run_count(), pick_run_value());
               else take_units(pick_take_count());
            end
         end
      end
   endtask

   initial begin
      int        span;
      int        mode;
      int        cycles;
      bit        held;
      logic [7:0] pattern;
      rsp_ready <= 1'b0;
      cycles     = 0;
      held       = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         span    = $urandom_range(16, 160);
         mode    = $urandom_range(0, 3);
         pattern = 8'($urandom());
         for (int i = 0; i < span; i++) begin
            case (mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(0, 1));
               2:       rsp_ready <= pattern[i % 8];
               default: rsp_ready <= ($urandom_range(0, 7) != 0);
            endcase
            @(posedge clock);
            cycles++;
         end
         if (!held && cycles >= HOLDOFF_AT) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
         end
      end
   end

   initial begin
      sum_checker     = new();
      items_sent      = 0;
      burst_left      = 0;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_kind       <= KIND_PUSH;
      req_run_count  <= '0;
      req_run_value  <= '0;
      req_take_count <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      run_random_traffic(items_sent + RANDOM_ITEMS);
      req_valid <= 1'b0;
      while (sum_checker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sum_checker.mismatches == 0 && sum_checker.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/rlq_pkg.sv
src/rlq_ram.sv
src/run_length_queue_take_sum_top.sv
sim/run_length_queue_take_sum_top_tb.sv
